// ===== rtl/ffea_pkg.sv =====
`timescale 1ns / 1ps
package ffea_pkg;
  localparam int unsigned MaxExtentsDefault  = 64;
  localparam int unsigned AddressBitsDefault = 48;
  // Wide enough for any supported address width.
  localparam int unsigned CtlBits = 64;
  localparam int unsigned CountBits = 7;

  localparam logic [1:0] OpFree     = 2'd0;
  localparam logic [1:0] OpAlloc    = 2'd1;
  localparam logic [1:0] OpCoalesce = 2'd2;
  localparam logic [1:0] OpUnused   = 2'd3;

  // Per-cycle command broadcast to every cell.
  typedef enum logic [2:0] {
    CmdHold,
    CmdLoad,
    CmdAlloc,
    CmdRemove,
    CmdSortStep,
    CmdMergeStep
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               phase;
    logic [CtlBits-1:0] key;
    logic [CtlBits-1:0] len;
  } ctl_t;
endpackage

// ===== rtl/first_fit_extent_allocator.sv =====
`timescale 1ns / 1ps
// First-fit free extent table built as a row of MAX_EXTENTS cells, one extent
// each. Free: the extent is loaded into the tail cell, or the full flag is set
// when no cell is free. Allocate: a parallel fit test finds the first fitting
// cell combinationally through a priority encoder; an exact fit then closes
// the gap by one neighbor shift of all later cells.
// Coalesce: odd-even transposition sort over the cell row, MAX_EXTENTS passes
// of neighbor compare/swap (one pass a cycle), then a merge walk that visits
// adjacent pairs one a cycle while no merge holds the walk, and shifts the row
// left on each merge.
// One request is in flight at a time; the result waits in an output register
// and the next request is taken once that result has gone out, or goes out in
// the same cycle. Odd-even transposition sort is stable since equal offsets
// never swap.
module first_fit_extent_allocator #(
  parameter int unsigned MAX_EXTENTS  = ffea_pkg::MaxExtentsDefault,
  parameter int unsigned ADDRESS_BITS = ffea_pkg::AddressBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [47:0] extent_offset_i,
  input  logic [47:0] extent_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] granted_offset_o,
  output logic        granted_o,
  output logic        table_full_o,
  output logic [6:0]  entries_used_o
);
  localparam int unsigned N  = MAX_EXTENTS;
  localparam int unsigned AW = ADDRESS_BITS;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned FB = ffea_pkg::CtlBits;

  typedef enum logic [2:0] {
    StIdle, StExec, StRemove, StSort, StMerge, StDone
  } state_e;

  state_e state_q;
  logic [1:0] op_q;
  logic [AW-1:0] key_q, len_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] pos_q;
  logic [CW-1:0] pass_q;
  logic [AW-1:0] gofs_q;
  logic g_q, full_q;
  logic res_valid_q;
  logic [47:0] res_ofs_q;
  logic res_g_q, res_full_q;
  logic [6:0] res_cnt_q;

  ffea_pkg::ctl_t ctl;
  logic [AW-1:0] st [N];
  logic [AW-1:0] ln [N];
  logic [N-1:0] fit, live, sel, rm, swp, mrg;
  logic [IW-1:0] first;
  logic any_fit;
  logic [AW:0] a_end, b_end, hi, lo, mlen_w;
  logic [AW-1:0] mlen;
  logic touch;
  logic pair_ok;

  always_comb begin
    for (int k = 0; k < N; k++) live[k] = (CW'(k) < cnt_q);
  end

  // First fitting cell.
  always_comb begin
    first = '0;
    any_fit = 1'b0;
    for (int k = N - 1; k >= 0; k--) begin
      if (fit[k]) begin
        first = IW'(k);
        any_fit = 1'b1;
      end
    end
  end

  // Merge test on the pair at pos_q, pos_q+1; pair_ok when both are live.
  always_comb begin
    logic [IW-1:0] p1;
    p1 = pos_q + IW'(1);
    pair_ok = ({1'b0, pos_q} + (IW + 1)'(1)) < (IW + 1)'(cnt_q);
    a_end = {1'b0, st[pos_q]} + {1'b0, ln[pos_q]};
    b_end = {1'b0, st[p1]} + {1'b0, ln[p1]};
    touch = ({1'b0, st[pos_q]} <= b_end) && (a_end >= {1'b0, st[p1]});
    hi = (a_end > b_end) ? a_end : b_end;
    lo = (st[pos_q] < st[p1]) ? {1'b0, st[pos_q]} : {1'b0, st[p1]};
    mlen_w = hi - lo;
    mlen = mlen_w[AW] ? '1 : mlen_w[AW-1:0];
  end

  always_comb begin
    ctl = '0;
    ctl.cmd = ffea_pkg::CmdHold;
    ctl.key = FB'(key_q);
    ctl.len = FB'(len_q);
    ctl.phase = pass_q[0];
    for (int k = 0; k < N; k++) begin
      sel[k] = (IW'(k) == first) && any_fit && (ln[k] != len_q);
      rm[k] = (IW'(k) >= pos_q);
      swp[k] = 1'b0;
      mrg[k] = 1'b0;
    end
    case (state_q)
      StExec: begin
        if (op_q == ffea_pkg::OpFree) ctl.cmd = ffea_pkg::CmdLoad;
        else if (op_q == ffea_pkg::OpAlloc) ctl.cmd = ffea_pkg::CmdAlloc;
        else ctl.cmd = ffea_pkg::CmdHold;
      end
      StRemove: ctl.cmd = ffea_pkg::CmdRemove;
      StSort: begin
        ctl.cmd = ffea_pkg::CmdSortStep;
        for (int k = 0; k + 1 < N; k++) begin
          swp[k] = ((k % 2) == int'(pass_q[0])) && live[k + 1] && (st[k] > st[k + 1]);
        end
      end
      StMerge: begin
        if (pair_ok && touch) begin
          ctl.cmd = ffea_pkg::CmdMergeStep;
          for (int k = 0; k < N; k++) mrg[k] = (IW'(k) == pos_q);
        end
      end
      default: ;
    endcase
  end

  // StMerge with touch: writes merged length (and min start is
  // already at pos since sorted), then remove pos+1 via StRemove.
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned R = (g + 1 < N) ? g + 1 : g;
    localparam int unsigned L = (g > 0) ? g - 1 : g;
    ffea_cell #(.AW(AW), .IDX(g)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i    (ctl),
      .live_i   (live[g]),
      .tail_i   (CW'(g) == cnt_q),
      .sel_i    (sel[g]),
      .rm_i     (rm[g]),
      .r_start_i(st[R]),
      .r_len_i  (ln[R]),
      .r_live_i (g + 1 < N),
      .l_start_i(st[L]),
      .l_len_i  (ln[L]),
      .l_swap_i ((g > 0) ? swp[L] : 1'b0),
      .swap_i   (swp[g]),
      .merge_i  (mrg[g]),
      .mlen_i   (mlen),
      .start_o  (st[g]),
      .len_o    (ln[g]),
      .fit_o    (fit[g])
    );
  end

  assign in_stall_o = (state_q != StIdle) || (res_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      res_valid_q <= 1'b0;
      op_q <= '0;
      key_q <= '0;
      len_q <= '0;
      pos_q <= '0;
      pass_q <= '0;
      g_q <= 1'b0;
      full_q <= 1'b0;
      gofs_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            op_q <= opcode_i;
            key_q <= AW'(extent_offset_i);
            len_q <= AW'(extent_size_i);
            g_q <= 1'b0;
            full_q <= 1'b0;
            gofs_q <= '0;
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q <= StDone;
          if (op_q == ffea_pkg::OpFree) begin
            if (cnt_q < CW'(N)) cnt_q <= cnt_q + CW'(1);
            else full_q <= 1'b1;
          end else if (op_q == ffea_pkg::OpAlloc) begin
            if (any_fit) begin
              g_q <= 1'b1;
              gofs_q <= st[first];
              if (ln[first] == len_q) begin
                pos_q <= first;
                state_q <= StRemove;
              end
            end
          end else if (op_q == ffea_pkg::OpCoalesce) begin
            if (cnt_q > CW'(1)) begin
              pass_q <= '0;
              state_q <= StSort;
            end
          end
        end
        StRemove: begin
          cnt_q <= cnt_q - CW'(1);
          if (op_q == ffea_pkg::OpCoalesce) begin
            // back to the merged cell for the next comparison
            pos_q <= pos_q - IW'(1);
            state_q <= StMerge;
          end else begin
            state_q <= StDone;
          end
        end
        StSort: begin
          pass_q <= pass_q + CW'(1);
          if (pass_q == CW'(N - 1)) begin
            pos_q <= '0;
            state_q <= StMerge;
          end
        end
        StMerge: begin
          if (!pair_ok) begin
            state_q <= StDone;
          end else if (touch) begin
            pos_q <= pos_q + IW'(1);
            state_q <= StRemove;
          end else begin
            pos_q <= pos_q + IW'(1);
          end
        end
        StDone: begin
          if (!res_valid_q || !out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StDone && (!res_valid_q || !out_stall_i)) res_valid_q <= 1'b1;
      else if (!out_stall_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && (!res_valid_q || !out_stall_i)) begin
      res_ofs_q <= 48'(gofs_q);
      res_g_q <= g_q;
      res_full_q <= full_q;
      res_cnt_q <= (cnt_q > CW'(127)) ? 7'd127 : 7'(cnt_q);
    end
  end

  assign out_valid_o = res_valid_q;
  assign granted_offset_o = res_ofs_q;
  assign granted_o = res_g_q;
  assign table_full_o = res_full_q;
  assign entries_used_o = res_cnt_q;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N)) else $error("count over capacity");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accepted while busy");
  a_grant_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> !table_full_o) else $error("grant with full");
`endif
endmodule

// ===== rtl/ffea_cell.sv =====
`timescale 1ns / 1ps
// One table slot. Talks to left and right neighbors only.
module ffea_cell #(
  parameter int unsigned AW = ffea_pkg::AddressBitsDefault,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ffea_pkg::ctl_t ctl_i,
  input  logic          live_i,       // slot index < used count
  input  logic          tail_i,       // slot index == used count (load target)
  input  logic          sel_i,        // alloc: this slot chosen
  input  logic          rm_i,         // remove: slot at or after removed point
  input  logic [AW-1:0] r_start_i,
  input  logic [AW-1:0] r_len_i,
  input  logic          r_live_i,
  input  logic [AW-1:0] l_start_i,
  input  logic [AW-1:0] l_len_i,
  input  logic          l_swap_i,     // left neighbor pair swaps with us
  input  logic          swap_i,       // we swap with right neighbor
  input  logic          merge_i,      // we absorb right neighbor
  input  logic [AW-1:0] mlen_i,
  output logic [AW-1:0] start_o,
  output logic [AW-1:0] len_o,
  output logic          fit_o
);
  logic [AW-1:0] start_q, start_d, len_q, len_d;
  logic [AW-1:0] key, req;

  assign key = ctl_i.key[AW-1:0];
  assign req = ctl_i.len[AW-1:0];
  assign start_o = start_q;
  assign len_o = len_q;
  assign fit_o = live_i && (len_q >= req);

  always_comb begin
    start_d = start_q;
    len_d = len_q;
    case (ctl_i.cmd)
      ffea_pkg::CmdLoad: begin
        if (tail_i) begin
          start_d = key;
          len_d = req;
        end
      end
      ffea_pkg::CmdAlloc: begin
        if (sel_i) begin
          start_d = start_q + req;
          len_d = len_q - req;
        end
      end
      ffea_pkg::CmdRemove: begin
        if (rm_i && r_live_i) begin
          start_d = r_start_i;
          len_d = r_len_i;
        end
      end
      ffea_pkg::CmdSortStep: begin
        if (swap_i) begin
          start_d = r_start_i;
          len_d = r_len_i;
        end else if (l_swap_i) begin
          start_d = l_start_i;
          len_d = l_len_i;
        end
      end
      ffea_pkg::CmdMergeStep: begin
        if (merge_i) len_d = mlen_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q <= len_d;
  end

  logic unused;
  assign unused = ^{rst_ni, IDX[0], ctl_i.phase};
endmodule
